/* rtl/x86rfs_pkg.sv */
// Package for the x86 register file and stack block.
// Access-mode codes, controller states and the controller-to-datapath command struct.
// No dependencies.
package x86rfs_pkg;

   typedef enum logic [3:0] {
      MODE_RD32_REG = 4'd0,
      MODE_WR32_REG = 4'd1,
      MODE_RD8_REG  = 4'd2,
      MODE_WR8_REG  = 4'd3,
      MODE_RD32_MEM = 4'd4,
      MODE_WR32_MEM = 4'd5,
      MODE_RD8_MEM  = 4'd6,
      MODE_WR8_MEM  = 4'd7,
      MODE_PUSH     = 4'd8,
      MODE_POP      = 4'd9
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request beat
      logic execute;   // perform register/memory side effects, launch memory read
      logic load_out;  // move the result into the response register
   } cmd_type;

   localparam int unsigned REG_COUNT  = 8;
   localparam int unsigned WORD_BYTES = 4;
   localparam logic [2:0]  STACK_REG  = 3'd4;
   localparam logic [31:0] STACK_STEP = 32'd4;
   localparam logic [31:0] KEEP_HI24  = 32'hffffff00;
   localparam logic [31:0] KEEP_NOT_B1 = 32'hffff00ff;
   localparam logic [7:0]  BYTE_MASK  = 8'hFF;

endpackage

/* rtl/x86rfs_ctrl.sv */
// Controller for the x86 register file and stack block.
// Sequences capture, execute and response load; owns the handshake state.
// Depends on x86rfs_pkg.
module x86rfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output x86rfs_pkg::cmd_type cmd
);
   import x86rfs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/x86rfs_dp.sv */
// Datapath for the x86 register file and stack block.
// Register file flops, four byte-lane memories, request and response registers.
// Depends on x86rfs_pkg.
module x86rfs_dp #(
   parameter int unsigned MEMORY_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  x86rfs_pkg::cmd_type cmd,
   input  logic [3:0]          req_mode,
   input  logic [2:0]          req_reg_index,
   input  logic [15:0]         req_mem_address,
   input  logic [31:0]         req_write_value,
   output logic [31:0]         rsp_read_data
);
   import x86rfs_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MEMORY_BYTES);
   localparam int unsigned ROW_W  = ADDR_W - 2;
   localparam int unsigned ROWS   = MEMORY_BYTES / WORD_BYTES;

   // captured request
   logic [3:0]  mode_ff;
   logic [2:0]  idx_ff;
   logic [15:0] addr_ff;
   logic [31:0] wval_ff;

   logic [31:0] rf_ff [REG_COUNT];
   logic [31:0] res_ff, res_in;
   logic [1:0]  off_ff;
   logic [31:0] q_word;      // registered lane read data, lane k in bits 8k+7:8k
   logic [31:0] rsp_data_ff;

   // execute-cycle controls
   logic             rf_we;
   logic [2:0]       rf_widx;
   logic [31:0]      rf_wdata;
   logic             mem_re;
   logic             mem_we_word;
   logic             mem_we_byte;
   logic [31:0]      sp_dec;
   logic [31:0]      acc_addr;
   logic [ADDR_W-1:0] eff_addr;
   logic [ROW_W-1:0] row_base;
   logic [1:0]       off;
   logic [31:0]      rf_sel;
   logic [31:0]      rf_lo;
   logic [31:0]      mem_word;
   logic [31:0]      out_value;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         idx_ff  <= req_reg_index;
         addr_ff <= req_mem_address;
         wval_ff <= req_write_value;
      end
   end

   assign sp_dec   = rf_ff[STACK_REG] - STACK_STEP;
   assign rf_sel   = rf_ff[idx_ff];
   assign rf_lo    = rf_ff[{1'b0, idx_ff[1:0]}];

   always_comb begin
      rf_we       = 1'b0;
      rf_widx     = idx_ff;
      rf_wdata    = wval_ff;
      mem_re      = 1'b0;
      mem_we_word = 1'b0;
      mem_we_byte = 1'b0;
      acc_addr    = {16'b0, addr_ff};
      res_in      = '0;
      unique case (mode_ff)
         MODE_RD32_REG: res_in = rf_sel;
         MODE_WR32_REG: rf_we  = 1'b1;
         MODE_RD8_REG:  res_in = {24'b0, idx_ff[2] ? rf_lo[15:8] : rf_lo[7:0]};
         MODE_WR8_REG: begin
            rf_we   = 1'b1;
            rf_widx = {1'b0, idx_ff[1:0]};
            if (idx_ff[2]) begin
               rf_wdata = (rf_lo & KEEP_NOT_B1) | {16'b0, wval_ff[7:0] & BYTE_MASK, 8'b0};
            end else begin
               rf_wdata = (rf_lo & KEEP_HI24) | {24'b0, wval_ff[7:0] & BYTE_MASK};
            end
         end
         MODE_RD32_MEM, MODE_RD8_MEM: mem_re = 1'b1;
         MODE_WR32_MEM: mem_we_word = 1'b1;
         MODE_WR8_MEM:  mem_we_byte = 1'b1;
         MODE_PUSH: begin
            rf_we       = 1'b1;
            rf_widx     = STACK_REG;
            rf_wdata    = sp_dec;
            acc_addr    = sp_dec;
            mem_we_word = 1'b1;
         end
         MODE_POP: begin
            rf_we    = 1'b1;
            rf_widx  = STACK_REG;
            rf_wdata = rf_ff[STACK_REG] + STACK_STEP;
            acc_addr = rf_ff[STACK_REG];
            mem_re   = 1'b1;
         end
         default: ;
      endcase
   end

   assign eff_addr = acc_addr[ADDR_W-1:0];
   assign row_base = eff_addr[ADDR_W-1:2];
   assign off      = eff_addr[1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= '0;
         end
      end else if (cmd.execute && rf_we) begin
         rf_ff[rf_widx] <= rf_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         res_ff <= res_in;
         off_ff <= off;
      end
   end

   // Byte lane k holds addresses with addr[1:0] == k. A word that starts at
   // offset off uses row_base for lanes >= off and the next row (wrapping)
   // for lanes below it.
   for (genvar k = 0; k < WORD_BYTES; k++) begin : g_lane
      logic [7:0]       mem [ROWS];
      logic [ROW_W-1:0] row;
      logic [1:0]       pos;
      logic             we;
      logic [7:0]       wdata;
      logic [7:0]       q_ff;

      assign pos   = 2'(k) - off;   // byte of the word that lands in this lane
      assign row   = (2'(k) >= off) ? row_base : row_base + ROW_W'(1);
      assign we    = cmd.execute && (mem_we_word || (mem_we_byte && pos == 2'd0));
      assign wdata = wval_ff[8*pos +: 8];

      always_ff @(posedge clock) begin
         if (we) begin
            mem[row] <= wdata;
         end else if (cmd.execute && mem_re) begin
            q_ff <= mem[row];
         end
      end

      assign q_word[8*k +: 8] = q_ff;
   end

   always_comb begin : p_word_mux
      logic [1:0] sel;
      sel = '0;
      for (int j = 0; j < WORD_BYTES; j++) begin
         sel                = 2'(j) + off_ff;
         mem_word[8*j +: 8] = q_word[8*sel +: 8];
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_RD32_MEM, MODE_POP: out_value = mem_word;
         MODE_RD8_MEM:            out_value = {24'b0, mem_word[7:0]};
         default:                 out_value = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= out_value;
      end
   end

   assign rsp_read_data = rsp_data_ff;

endmodule

/* rtl/x86_register_file_and_stack_top.sv */
// Top level of the x86 register file and stack block.
// Instantiates x86rfs_ctrl and x86rfs_dp; depends on x86rfs_pkg.
//
// One request beat performs one access chosen by req_mode: read or write a
// 32-bit register, read or write an 8-bit register (indices 0-3 are bits
// 7:0 of registers 0-3, indices 4-7 bits 15:8), read or write memory as a
// little-endian word or a byte, or push/pop a word through ESP (register 4).
// Every request yields exactly one response beat; writes, pushes and unused
// modes answer zero. Memory addresses wrap at MEMORY_BYTES, which must be a
// power of two (16 to 16M); memory is split into four byte lanes so an
// unaligned or wrapping word takes one access. Memory has no reset: reading
// a byte that was never written returns an undefined value. The register
// file resets to zero. Items are handled one at a time: accept, execute
// (register update, lane writes or lane reads), then result load, and the next
// request is taken in the cycle after the result is loaded; a stalled
// response holds the block in the load step.
module x86_register_file_and_stack_top #(
   parameter int unsigned MEMORY_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_mode,
   input  logic [2:0]  req_reg_index,
   input  logic [15:0] req_mem_address,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data
);
   import x86rfs_pkg::*;

   cmd_type cmd;

   x86rfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   x86rfs_dp #(
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_reg_index   (req_reg_index),
      .req_mem_address (req_mem_address),
      .req_write_value (req_write_value),
      .rsp_read_data   (rsp_read_data)
   );

endmodule

/* rtl/x86rfs_checker.sv */
// Port-level checks for the x86 register file and stack block.
// Bound to x86_register_file_and_stack_top; no package dependency.
module x86rfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("response beat dropped or changed while stalled");

   // one item in flight: no new request beat right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request accepted while an item was in progress");

   // with the response side empty, the result shows after the execute and load steps
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |-> ##3 rsp_valid)
      else $error("response beat late");

   // a response appears only after a request beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready, 1) && $past(!req_ready, 2))
      else $error("response beat without a request");

endmodule

bind x86_register_file_and_stack_top x86rfs_checker u_checker (.*);
